### design/b64d_pkg.sv
package b64d_pkg;

	// padding character of the base64 text
	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// number of bytes one group of four characters yields
	localparam int unsigned GROUP_BYTES = 3;

	// alphabet lookup result
	typedef struct packed {
		logic       hit;
		logic [5:0] val;
	} sextet_t;

	// results caused by one character, handed from the decoder to the serializer
	typedef struct packed {
		logic [1:0]                  count;
		logic [GROUP_BYTES-1:0][7:0] bytes;
		logic                        byte_valid;
		logic                        msg_end;
	} dec_res_t;

	// map a character code to its 6-bit value, codes 128 and up never hit
	function automatic sextet_t b64_lookup(input logic [7:0] ch);
		sextet_t r;
		r = '{hit: 1'b0, val: 6'd0};
		case (ch) inside
			[8'h41:8'h5A]: begin
				r.hit = 1'b1;
				r.val = 6'(ch - 8'h41);
			end
			[8'h61:8'h7A]: begin
				r.hit = 1'b1;
				r.val = 6'(ch - 8'h47);
			end
			[8'h30:8'h39]: begin
				r.hit = 1'b1;
				r.val = 6'(ch + 8'h04);
			end
			8'h2B: begin
				r.hit = 1'b1;
				r.val = 6'h3E;
			end
			8'h2F: begin
				r.hit = 1'b1;
				r.val = 6'h3F;
			end
			default: begin
				r.hit = 1'b0;
			end
		endcase
		return r;
	endfunction

endpackage

### design/base64_decoder_core.sv
// Streaming base64 decoder, one text character per input transaction.
// Input channel: text_char, end_of_message with in_valid/in_ready.
// Output channel: data_byte, byte_valid, run_last, message_end with
// out_valid/out_ready; each character yields zero to three results.
// Alphabet characters are collected; the fourth one emits three bytes.
// The first '=' flushes held values as bytes and mutes the rest of the
// message. end_of_message clears state; if that character gave no byte,
// one empty result (byte_valid 0) carries run_last and message_end.
// A character is taken into the input register, decoded from there into
// the result buffer once it frees, and its first result offered from it.
// Throughput: one character per cycle while each gives at most one
// result and out_ready is high; a character giving several results
// holds the output until the single-result port has taken each. Skipped
// characters pass the input register even while the result buffer drains.
// The input register acts as a skid stage: a new character is taken while
// results wait on a stalled receiver, then in_ready drops.
// Reset clears the held values, padding flag and both buffers at once.
module base64_decoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] text_char,
	input  logic       end_of_message,
	input  logic       in_valid,
	output logic       in_ready,
	output logic [7:0] data_byte,
	output logic       byte_valid,
	output logic       run_last,
	output logic       message_end,
	output logic       out_valid,
	input  logic       out_ready
);
	import b64d_pkg::*;

	logic       vld_s1;
	logic [7:0] char_s1;
	logic       eom_s1;
	dec_res_t   res;
	logic       load_ready;
	logic       consume;

	// the held character moves on when it yields nothing or the buffer frees
	assign consume  = vld_s1 && (res.count == 2'd0 || load_ready);
	assign in_ready = !vld_s1 || consume;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= text_char;
			eom_s1  <= end_of_message;
		end
	end

	b64d_decode u_decode (
		.clk            (clk),
		.arst_n         (arst_n),
		.text_char      (char_s1),
		.end_of_message (eom_s1),
		.consume        (consume),
		.res            (res)
	);

	b64d_serializer u_serializer (
		.clk         (clk),
		.arst_n      (arst_n),
		.res         (res),
		.load        (consume),
		.load_ready  (load_ready),
		.data_byte   (data_byte),
		.byte_valid  (byte_valid),
		.run_last    (run_last),
		.message_end (message_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready)
	);

endmodule

### design/b64d_decode.sv
module b64d_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        text_char,
	input  logic              end_of_message,
	input  logic              consume,
	output b64d_pkg::dec_res_t res
);
	import b64d_pkg::*;

	logic [17:0] acc_q;
	logic [1:0]  held_q;
	logic        pad_seen_q;

	sextet_t     lut;
	logic [23:0] full;
	logic [17:0] acc_d;
	logic [1:0]  held_d;
	logic        pad_seen_d;

	assign lut  = b64_lookup(text_char);
	assign full = {acc_q, lut.val};

	// character decode and next accumulator state
	always_comb begin
		res        = '0;
		acc_d      = acc_q;
		held_d     = held_q;
		pad_seen_d = pad_seen_q;
		if (!pad_seen_q) begin
			if (text_char == PAD_CHAR) begin
				if (held_q == 2'd3) begin
					res.count    = 2'd2;
					res.bytes[0] = acc_q[17:10];
					res.bytes[1] = acc_q[9:2];
				end else if (held_q == 2'd2) begin
					res.count    = 2'd1;
					res.bytes[0] = acc_q[11:4];
				end
				pad_seen_d = 1'b1;
				acc_d      = '0;
				held_d     = '0;
			end else if (lut.hit) begin
				if (held_q == 2'd3) begin
					res.count    = 2'd3;
					res.bytes[0] = full[23:16];
					res.bytes[1] = full[15:8];
					res.bytes[2] = full[7:0];
					acc_d        = '0;
					held_d       = '0;
				end else begin
					acc_d  = {acc_q[11:0], lut.val};
					held_d = held_q + 2'd1;
				end
			end
		end
		res.byte_valid = (res.count != 2'd0);
		// message end: clear state, emit an empty marker if nothing else
		if (end_of_message) begin
			res.msg_end = 1'b1;
			if (res.count == 2'd0) begin
				res.count = 2'd1;
			end
			acc_d      = '0;
			held_d     = '0;
			pad_seen_d = 1'b0;
		end
	end

	// accumulator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			held_q     <= '0;
			pad_seen_q <= 1'b0;
		end else if (consume) begin
			acc_q      <= acc_d;
			held_q     <= held_d;
			pad_seen_q <= pad_seen_d;
		end
	end

	// after padding nothing is held
	a_pad_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pad_seen_q |-> (held_q == 2'd0 && acc_q == 18'd0))
		else $error("values held after padding");

	// message end leaves a clean state
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && end_of_message) |=> (held_q == 2'd0 && !pad_seen_q))
		else $error("state not cleared at message end");

	// a full group only comes from a fourth value
	a_group_src: assert property (@(posedge clk) disable iff (!arst_n)
		(res.count == 2'd3) |-> (held_q == 2'd3 && lut.hit))
		else $error("three bytes without a complete group");

endmodule

### design/b64d_serializer.sv
module b64d_serializer (
	input  logic               clk,
	input  logic               arst_n,
	input  b64d_pkg::dec_res_t res,
	input  logic               load,
	output logic               load_ready,
	output logic [7:0]         data_byte,
	output logic               byte_valid,
	output logic               run_last,
	output logic               message_end,
	output logic               out_valid,
	input  logic               out_ready
);
	import b64d_pkg::*;

	logic [GROUP_BYTES-1:0][7:0] bytes_q;
	logic [1:0]                  cnt_q;
	logic                        bv_q;
	logic                        msg_end_q;
	logic                        take;

	// buffer frees up when empty or its last result leaves now
	assign out_valid  = (cnt_q != 2'd0);
	assign take       = out_valid && out_ready;
	assign load_ready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready);

	assign data_byte   = bytes_q[0];
	assign byte_valid  = bv_q;
	assign run_last    = (cnt_q == 2'd1);
	assign message_end = msg_end_q && (cnt_q == 2'd1);

	// result count and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			bv_q      <= 1'b0;
			msg_end_q <= 1'b0;
		end else if (load && load_ready && res.count != 2'd0) begin
			cnt_q     <= res.count;
			bv_q      <= res.byte_valid;
			msg_end_q <= res.msg_end;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// byte shift line, front byte goes out
	always_ff @(posedge clk) begin
		if (load && load_ready && res.count != 2'd0) begin
			bytes_q <= res.bytes;
		end else if (take) begin
			bytes_q <= {8'd0, bytes_q[GROUP_BYTES-1:1]};
		end
	end

	// an empty marker is always a lone result
	a_marker_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !byte_valid) |-> (run_last && message_end))
		else $error("empty marker is not a lone end result");

	// loading never overwrites results still owed
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(load && load_ready && res.count != 2'd0 && cnt_q != 2'd0) |-> take)
		else $error("result buffer overwritten");

endmodule

### tb/b64d_byte_checker.sv
module b64d_byte_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] text_char,
	input  logic       end_of_message,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       byte_valid,
	input  logic       run_last,
	input  logic       message_end,
	input  logic       out_valid,
	input  logic       out_ready,
	output int         mismatches,
	output int         bytes_outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import b64d_pkg::*;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       run_last;
		logic       message_end;
	} byte_result_t;

	// decoded results not yet seen on the output channel, oldest first
	byte_result_t bytes_due[$];

	// decoder state as the design should hold it
	logic [17:0] sextets;
	logic [1:0]  held;
	logic        padded;

	byte_result_t want;
	int          errs;

	// alphabet position of a character, hit low outside the alphabet
	function automatic sextet_t char_sextet(input logic [7:0] c);
		sextet_t s;
		s.hit = 1'b1;
		s.val = 6'd0;
		if (c >= "A" && c <= "Z")
			s.val = 6'(c - "A");
		else if (c >= "a" && c <= "z")
			s.val = 6'(c - "a" + 26);
		else if (c >= "0" && c <= "9")
			s.val = 6'(c - "0" + 52);
		else if (c == "+")
			s.val = 6'd62;
		else if (c == "/")
			s.val = 6'd63;
		else
			s.hit = 1'b0;
		return s;
	endfunction

	// decode one accepted character and queue the results it causes
	task automatic decode_char(input logic [7:0] c, input logic eom);
		byte_result_t burst[$];
		byte_result_t r;
		sextet_t      s;
		logic [23:0]  group;
		s = char_sextet(c);
		r = '0;
		r.byte_valid = 1'b1;
		if (!padded) begin
			if (c == PAD_CHAR) begin
				// padding flushes whatever whole bytes the held sextets make
				if (held == 2'd3) begin
					r.data_byte = sextets[17:10];
					burst.push_back(r);
					r.data_byte = sextets[9:2];
					burst.push_back(r);
				end else if (held == 2'd2) begin
					r.data_byte = sextets[11:4];
					burst.push_back(r);
				end
				padded = 1'b1;
				sextets = '0;
				held = 2'd0;
			end else if (s.hit) begin
				if (held == 2'd3) begin
					group = {sextets, s.val};
					r.data_byte = group[23:16];
					burst.push_back(r);
					r.data_byte = group[15:8];
					burst.push_back(r);
					r.data_byte = group[7:0];
					burst.push_back(r);
					sextets = '0;
					held = 2'd0;
				end else begin
					sextets = {sextets[11:0], s.val};
					held = held + 2'd1;
				end
			end
		end
		// end of message: empty marker if nothing came out, then clear
		if (eom) begin
			if (burst.size() == 0)
				burst.push_back('0);
			burst[burst.size()-1].message_end = 1'b1;
			sextets = '0;
			held = 2'd0;
			padded = 1'b0;
		end
		if (burst.size() > 0)
			burst[burst.size()-1].run_last = 1'b1;
		foreach (burst[i])
			bytes_due.push_back(burst[i]);
	endtask

	// predict on input transactions, compare on output transactions
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sextets = '0;
			held = 2'd0;
			padded = 1'b0;
			bytes_due.delete();
			errs = 0;
			mismatches <= 0;
			bytes_outstanding <= 0;
		end else begin
			if (in_valid && in_ready)
				decode_char(text_char, end_of_message);
			if (out_valid && out_ready) begin
				if (bytes_due.size() == 0) begin
					$error("unexpected result: data_byte %02h byte_valid %0b", data_byte,
						byte_valid);
					errs++;
				end else begin
					want = bytes_due.pop_front();
					if (data_byte !== want.data_byte) begin
						$error("data_byte: expected %02h, got %02h", want.data_byte, data_byte);
						errs++;
					end
					if (byte_valid !== want.byte_valid) begin
						$error("byte_valid: expected %0b, got %0b", want.byte_valid, byte_valid);
						errs++;
					end
					if (run_last !== want.run_last) begin
						$error("run_last: expected %0b, got %0b", want.run_last, run_last);
						errs++;
					end
					if (message_end !== want.message_end) begin
						$error("message_end: expected %0b, got %0b", want.message_end,
							message_end);
						errs++;
					end
				end
			end
			mismatches <= errs;
			bytes_outstanding <= bytes_due.size();
		end
	end

endmodule

### tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import b64d_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic [7:0] text_char = 8'h00;
	logic       end_of_message = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       run_last;
	logic       message_end;
	logic       out_valid;
	logic       out_ready = 1'b0;

	int mismatches;
	int bytes_outstanding;
	int tx_idle_pct = 33;
	int rx_idle_pct = 74;
	int decoded_chars;

	base64_decoder_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.text_char     (text_char),
		.end_of_message(end_of_message),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.byte_valid    (byte_valid),
		.run_last      (run_last),
		.message_end   (message_end),
		.out_valid     (out_valid),
		.out_ready     (out_ready)
	);

	b64d_byte_checker checker_i (
		.clk              (clk),
		.arst_n           (arst_n),
		.text_char        (text_char),
		.end_of_message   (end_of_message),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.data_byte        (data_byte),
		.byte_valid       (byte_valid),
		.run_last         (run_last),
		.message_end      (message_end),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.mismatches       (mismatches),
		.bytes_outstanding(bytes_outstanding)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver backpressure
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// run limit
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	// one character per transaction, random gaps before it
	task automatic send(input logic [7:0] c, input logic eom);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		text_char <= c;
		end_of_message <= eom;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_text(input string s, input bit end_at_last);
		for (int i = 0; i < s.len(); i++)
			send(s[i], end_at_last && (i == s.len() - 1));
	endtask

	// alphabet character for a 6-bit value
	function automatic logic [7:0] b64_char(input logic [5:0] v);
		if (v < 26)
			return 8'("A" + v);
		else if (v < 52)
			return 8'("a" + v - 26);
		else if (v < 62)
			return 8'("0" + v - 52);
		else if (v == 62)
			return "+";
		else
			return "/";
	endfunction

	// a character outside the alphabet and not padding
	function automatic logic [7:0] noise_char();
		logic [7:0] c;
		case ($urandom_range(0, 3))
			0: c = 8'($urandom_range(128, 255));
			1: c = 8'($urandom_range(0, 8'h2A));
			2: c = 8'($urandom_range(8'h3A, 8'h40));
			default: c = $urandom_range(0, 1) ? 8'($urandom_range(8'h5B, 8'h60))
				: 8'($urandom_range(8'h7B, 8'h7F));
		endcase
		if (c == PAD_CHAR)
			c = 8'h3E;
		return c;
	endfunction

	// mostly well-formed messages with random content, some broken ones
	task automatic send_random_message();
		logic [7:0] msg[$];
		int         ngroups;
		int         nchars;
		int         r;
		bit         with_end;
		with_end = 1'b1;
		if ($urandom_range(0, 9) < 8) begin
			ngroups = $urandom_range(0, 3);
			case ($urandom_range(0, 3))
				1: nchars = ngroups * 4 + 2;
				2: nchars = ngroups * 4 + 3;
				3: nchars = ngroups * 4 + $urandom_range(1, 3);
				default: nchars = ngroups * 4;
			endcase
			for (int i = 0; i < nchars; i++) begin
				if ($urandom_range(0, 9) == 0)
					msg.push_back(noise_char());
				msg.push_back(b64_char(6'($urandom_range(0, 63))));
				decoded_chars++;
			end
			// padding after a two or three character tail
			if (nchars % 4 == 2 && $urandom_range(0, 3) != 0) begin
				msg.push_back(PAD_CHAR);
				msg.push_back(PAD_CHAR);
				decoded_chars += 2;
			end else if (nchars % 4 == 3 && $urandom_range(0, 3) != 0) begin
				msg.push_back(PAD_CHAR);
				decoded_chars++;
			end
		end else begin
			// broken message: random mix of anything
			with_end = ($urandom_range(0, 9) < 7);
			repeat ($urandom_range(1, 8)) begin
				r = $urandom_range(0, 9);
				if (r < 4)
					msg.push_back(b64_char(6'($urandom_range(0, 63))));
				else if (r < 6)
					msg.push_back(PAD_CHAR);
				else
					msg.push_back(8'($urandom_range(0, 255)));
				decoded_chars++;
			end
		end
		if (msg.size() == 0)
			msg.push_back(noise_char());
		foreach (msg[i])
			send(msg[i], with_end && (i == msg.size() - 1));
	endtask

	task automatic random_phase(input int n);
		decoded_chars = 0;
		while (decoded_chars < n)
			send_random_message();
	endtask

	// stimulus and verdict
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every alphabet edge, full groups, end on a group boundary
		send_text("Za09", 1'b0);
		send_text("+/Az", 1'b1);
		// two held then padding, second padding ignored, empty end
		send_text("QQ==", 1'b1);
		// three held then padding ending the message
		send_text("TWE=", 1'b1);
		// one held then padding, later characters ignored
		send_text("A=", 1'b0);
		send(8'hFF, 1'b0);
		send_text("B", 1'b1);
		// non-alphabet codes skipped, leftover sextets dropped at end
		send(8'h00, 1'b0);
		send(8'h80, 1'b0);
		send_text("AB", 1'b0);
		send(8'h7F, 1'b1);

		random_phase(40);
		tx_idle_pct = 74;
		rx_idle_pct = 33;
		random_phase(40);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		random_phase(40);

		in_valid <= 1'b0;
		@(posedge clk);
		while (bytes_outstanding != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### filelist.f
design/b64d_pkg.sv
design/b64d_decode.sv
design/b64d_serializer.sv
design/base64_decoder_core.sv
tb/b64d_byte_checker.sv
tb/tb.sv
